>>> rtl/core/lpom_pkg.sv
// Shared types and constants for the low-pulse occupancy meter.
package lpom_pkg;

  localparam logic [1:0] KIND_PIN   = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;

  localparam int          NUM_W     = 42;
  localparam int          DIV_STEPS = NUM_W;
  localparam int          CNT_W     = $clog2(DIV_STEPS);
  localparam logic [9:0]  PPM_SCALE = 10'd1000;
  localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
  localparam logic [2:0]  ADDR_ENABLE = 3'd0;

  typedef struct packed {
    logic [1:0]  kind;
    logic        channel;
    logic        level;
    logic [31:0] now_us;
    logic [31:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic        out_channel;
    logic [31:0] ratio_ppm;
    logic        saturated;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic load_short;
    logic mul;
    logic div_step;
    logic load_long;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic long_read;
    logic div_last;
  } status_t;

endpackage

>>> rtl/core/low_pulse_occupancy_meter.sv
// Top level of the low-pulse occupancy meter: config register, controller and datapath.
//
// Input words (in_valid/in_stall/in_data) are pin changes, read requests or
// start words. Pin changes, starts and disabled reads complete at the accept
// edge; a disabled or out-of-range read loads a zero result into the output
// register at that same edge.
// An enabled read runs from the accept edge through ST_MUL for the x1000
// multiply, ST_DIV for the restoring divider (one quotient bit per cycle)
// and ST_DONE, which loads the result once the output register is free. No
// new word is taken until the controller is back in ST_IDLE.
// Results leave through an output register (out_valid/out_stall/out_data).
// in_stall stays high for the whole read, and longer while a finished result
// waits for a stalled output register. While a result is stalled and no read
// is running, pin changes and starts are still taken; a read waits until the
// output register frees.
// Reset clears all channel timers, the enable bit and the output valid.
// enable lives at cfg byte address 0; the user must write it only while idle, the block does not enforce this.
module low_pulse_occupancy_meter #(
  parameter int NUM_CHANNELS = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lpom_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lpom_pkg::out_word_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  logic              enable_r;
  lpom_pkg::cmd_t    cmd;
  lpom_pkg::status_t status;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == lpom_pkg::ADDR_ENABLE[2]) ? {31'd0, enable_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[2] == lpom_pkg::ADDR_ENABLE[2])) begin
      enable_r <= cfg_pwdata[0];
    end
  end

  lpom_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  lpom_dp #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .enable   (enable_r),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

>>> rtl/core/lpom_dp.sv
// Datapath: per-channel timers, scale multiply, restoring divider, result register.
module lpom_dp #(
  parameter int NUM_CHANNELS = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               enable,
  input  lpom_pkg::in_word_t in_data,
  input  lpom_pkg::cmd_t     cmd,
  output lpom_pkg::status_t  status,
  output lpom_pkg::out_word_t out_data
);

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [31:0] start_r [NUM_CHANNELS];
  logic [31:0] total_r [NUM_CHANNELS];
  logic [31:0] last_r  [NUM_CHANNELS];

  logic [31:0]              cap_r;
  logic [31:0]              den_r;
  logic                     ch_r;
  logic [lpom_pkg::NUM_W-1:0] num_r;
  logic [31:0]              rem_r;
  logic [lpom_pkg::CNT_W-1:0] cnt_r;
  lpom_pkg::out_word_t      out_r;

  logic [CH_W-1:0] idx;
  logic            ch_ok;
  logic            long_read;
  logic [32:0]     rem_sh;
  logic            ge;
  logic [32:0]     rem_sub;
  logic            sat;

  assign idx       = CH_W'(in_data.channel);
  assign ch_ok     = (32'(in_data.channel) < NUM_CHANNELS);
  assign long_read = (in_data.kind == lpom_pkg::KIND_READ) && enable && ch_ok;

  assign status.is_read   = (in_data.kind == lpom_pkg::KIND_READ);
  assign status.long_read = long_read;
  assign status.div_last  = (cnt_r == lpom_pkg::CNT_W'(lpom_pkg::DIV_STEPS - 1));

  assign rem_sh  = {rem_r, num_r[lpom_pkg::NUM_W-1]};
  assign ge      = (rem_sh >= {1'b0, den_r});
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign sat     = (den_r == 32'd0) || (|num_r[lpom_pkg::NUM_W-1:32]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        start_r[i] <= 32'd0;
        total_r[i] <= 32'd0;
        last_r[i]  <= 32'd0;
      end
    end else if (cmd.accept) begin
      case (in_data.kind)
        lpom_pkg::KIND_PIN: begin
          if (ch_ok) begin
            if (!in_data.level) begin
              start_r[idx] <= in_data.now_us;
            end else begin
              total_r[idx] <= total_r[idx] + (in_data.now_us - start_r[idx]);
            end
          end
        end
        lpom_pkg::KIND_START: begin
          for (int i = 0; i < NUM_CHANNELS; i++) begin
            total_r[i] <= 32'd0;
            last_r[i]  <= in_data.now_ms;
          end
        end
        lpom_pkg::KIND_READ: begin
          if (long_read) begin
            total_r[idx] <= 32'd0;
            last_r[idx]  <= in_data.now_ms;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && long_read) begin
      cap_r <= total_r[idx];
      den_r <= in_data.now_ms - last_r[idx];
      ch_r  <= in_data.channel;
    end
    if (cmd.mul) begin
      num_r <= lpom_pkg::NUM_W'(cap_r) * lpom_pkg::NUM_W'(lpom_pkg::PPM_SCALE);
      rem_r <= 32'd0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      num_r <= {num_r[lpom_pkg::NUM_W-2:0], ge};
      rem_r <= ge ? rem_sub[31:0] : rem_sh[31:0];
      cnt_r <= cnt_r + lpom_pkg::CNT_W'(1);
    end
    if (cmd.load_short) begin
      out_r.out_channel <= in_data.channel;
      out_r.ratio_ppm   <= 32'd0;
      out_r.saturated   <= 1'b0;
    end else if (cmd.load_long) begin
      out_r.out_channel <= ch_r;
      out_r.ratio_ppm   <= sat ? lpom_pkg::ALL_ONES : num_r[31:0];
      out_r.saturated   <= sat;
    end
  end

  assign out_data = out_r;

endmodule

>>> rtl/core/lpom_ctrl.sv
// Controller: sequences accept, multiply, divide and result load; owns the word handshakes.
module lpom_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  lpom_pkg::status_t status,
  output lpom_pkg::cmd_t    cmd
);

  lpom_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;
  logic accept;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != lpom_pkg::ST_IDLE) || (status.is_read && !out_free);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lpom_pkg::ST_IDLE: if (accept && status.long_read) state_nxt = lpom_pkg::ST_MUL;
      lpom_pkg::ST_MUL:  state_nxt = lpom_pkg::ST_DIV;
      lpom_pkg::ST_DIV:  if (status.div_last) state_nxt = lpom_pkg::ST_DONE;
      lpom_pkg::ST_DONE: if (out_free) state_nxt = lpom_pkg::ST_IDLE;
      default:           state_nxt = lpom_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.accept     = accept;
    cmd.load_short = accept && status.is_read && !status.long_read;
    case (state_r)
      lpom_pkg::ST_MUL:  cmd.mul = 1'b1;
      lpom_pkg::ST_DIV:  cmd.div_step = 1'b1;
      lpom_pkg::ST_DONE: cmd.load_long = out_free;
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_short || cmd.load_long) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpom_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/core/lpom_chk.sv
// Port-level checker for the occupancy meter, bound to the top level.
module lpom_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input lpom_pkg::in_word_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input lpom_pkg::out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result word changed while stalled");

  a_sat_ones: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |-> out_data.ratio_ppm == lpom_pkg::ALL_ONES)
    else $error("saturated result without all-ones ratio");

  a_reset_idle: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  a_pin_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.kind == lpom_pkg::KIND_PIN && !out_valid
      |=> !out_valid)
    else $error("pin change produced a result");

endmodule

bind low_pulse_occupancy_meter lpom_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> test/tb_low_pulse_occupancy_meter.sv
// Self-checking testbench for the low-pulse occupancy meter: random and directed words.
`timescale 1ns / 1ps

module tb_low_pulse_occupancy_meter;

  localparam int          NCH         = 2;
  localparam logic [1:0]  KIND_UNUSED = 2'd3;
  localparam int          TAIL_CYCLES = 60;
  localparam int          CYCLE_LIMIT = 600000;
  localparam int          HOLD_CYCLES = 500;
  localparam int          HOLD_AFTER  = 25;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  lpom_pkg::in_word_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  lpom_pkg::out_word_t out_data;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [2:0]          cfg_paddr = '0;
  logic [31:0]         cfg_pwdata = '0;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  low_pulse_occupancy_meter #(.NUM_CHANNELS(NCH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // meter shadow
  logic [31:0] fall_us [NCH];
  logic [31:0] low_sum_us [NCH];
  logic [31:0] read_mark_ms [NCH];
  logic        meter_on;

  lpom_pkg::in_word_t  pending_words[$];
  lpom_pkg::out_word_t expected_ratios[$];
  int          words_queued = 0;
  int          words_taken = 0;
  int          stim_count = 0;
  int          results_seen = 0;
  int          err_count = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;
  int          cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic [31:0] sim_us = 32'd0;
  logic [31:0] sim_ms = 32'd0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void meter_predict(input lpom_pkg::in_word_t w);
    lpom_pkg::out_word_t res;
    logic [31:0] elapsed;
    logic [63:0] scaled;
    logic [63:0] quo;
    case (w.kind)
      lpom_pkg::KIND_PIN: begin
        if (!w.level) fall_us[w.channel] = w.now_us;
        else low_sum_us[w.channel] = low_sum_us[w.channel] + (w.now_us - fall_us[w.channel]);
      end
      lpom_pkg::KIND_START: begin
        for (int i = 0; i < NCH; i++) begin
          low_sum_us[i] = '0;
          read_mark_ms[i] = w.now_ms;
        end
      end
      lpom_pkg::KIND_READ: begin
        res = '0;
        res.out_channel = w.channel;
        if (meter_on) begin
          elapsed = w.now_ms - read_mark_ms[w.channel];
          scaled = {32'b0, low_sum_us[w.channel]} * 64'd1000;
          read_mark_ms[w.channel] = w.now_ms;
          low_sum_us[w.channel] = '0;
          if (elapsed == '0) begin
            res.ratio_ppm = lpom_pkg::ALL_ONES;
            res.saturated = 1'b1;
          end else begin
            quo = scaled / {32'b0, elapsed};
            if (quo > {32'b0, lpom_pkg::ALL_ONES}) begin
              res.ratio_ppm = lpom_pkg::ALL_ONES;
              res.saturated = 1'b1;
            end else begin
              res.ratio_ppm = quo[31:0];
            end
          end
        end
        expected_ratios.push_back(res);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic check_result(input lpom_pkg::out_word_t got);
    lpom_pkg::out_word_t want;
    if (expected_ratios.size() == 0) begin
      report_mismatch($sformatf("unexpected word ch=%0d ratio=%h sat=%0d",
                                got.out_channel, got.ratio_ppm, got.saturated));
      return;
    end
    want = expected_ratios.pop_front();
    if (got.out_channel !== want.out_channel)
      report_mismatch($sformatf("out_channel %0d, want %0d", got.out_channel, want.out_channel));
    if (got.ratio_ppm !== want.ratio_ppm)
      report_mismatch($sformatf("ratio_ppm %h, want %h", got.ratio_ppm, want.ratio_ppm));
    if (got.saturated !== want.saturated)
      report_mismatch($sformatf("saturated %0d, want %0d", got.saturated, want.saturated));
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        meter_predict(in_data);
        words_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_result(out_data);
        results_seen++;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_low_pulse_occupancy_meter: errors");
      $finish;
    end
  end

  task automatic add_word(input logic [1:0] k, input logic ch, input logic lvl,
                          input logic [31:0] us, input logic [31:0] ms);
    lpom_pkg::in_word_t w;
    w.kind    = k;
    w.channel = ch;
    w.level   = lvl;
    w.now_us  = us;
    w.now_ms  = ms;
    pending_words.push_back(w);
    words_queued++;
    if (k != KIND_UNUSED) stim_count++;
  endtask

  // well-formed pulses on one channel, then a read of it
  task automatic add_pulse_burst();
    logic        ch;
    int          n;
    int unsigned span;
    ch = 1'($urandom_range(1));
    n = $urandom_range(4);
    span = 0;
    for (int i = 0; i < n; i++) begin
      add_word(lpom_pkg::KIND_PIN, ch, 1'b0, sim_us, $urandom);
      span = $urandom_range(200000, 1);
      sim_us += span;
      add_word(lpom_pkg::KIND_PIN, ch, 1'b1, sim_us, $urandom);
      span = $urandom_range(300000);
      sim_us += span;
    end
    sim_ms += $urandom_range(3000);
    add_word(lpom_pkg::KIND_READ, ch, 1'($urandom_range(1)), $urandom, sim_ms);
  endtask

  task automatic add_random_words(input int target);
    int   first;
    int   pick;
    logic ch;
    first = stim_count;
    while (stim_count - first < target) begin
      pick = $urandom_range(99);
      ch = 1'($urandom_range(1));
      if (pick < 65) begin
        add_pulse_burst();
      end else if (pick < 73) begin
        sim_ms += $urandom_range(100);
        add_word(lpom_pkg::KIND_START, ch, 1'($urandom_range(1)), $urandom, sim_ms);
      end else if (pick < 85) begin
        add_word(2'($urandom_range(3)), ch, 1'($urandom_range(1)), $urandom, $urandom);
      end else if (pick < 92) begin
        sim_ms += $urandom_range(50);
        add_word(lpom_pkg::KIND_READ, ch, 1'b0, $urandom, sim_ms);
        add_word(lpom_pkg::KIND_READ, ch, 1'b1, $urandom, sim_ms);
      end else begin
        // long low time over a short window
        add_word(lpom_pkg::KIND_PIN, ch, 1'b0, sim_us, $urandom);
        sim_us += $urandom_range(400000000, 5000000);
        add_word(lpom_pkg::KIND_PIN, ch, 1'b1, sim_us, $urandom);
        sim_ms += $urandom_range(3, 1);
        add_word(lpom_pkg::KIND_READ, ch, 1'b0, $urandom, sim_ms);
      end
    end
  endtask

  task automatic wait_idle();
    while (words_taken != words_queued || expected_ratios.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_enable(input logic v);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= lpom_pkg::ADDR_ENABLE;
    cfg_pwdata  <= {31'b0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    meter_on = v;
  endtask

  initial begin
    for (int i = 0; i < NCH; i++) begin
      fall_us[i] = '0;
      low_sum_us[i] = '0;
      read_mark_ms[i] = '0;
    end
    meter_on = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_enable(1'b1);
    // directed words
    add_word(lpom_pkg::KIND_READ, 1'b0, 1'b0, 32'd0, 32'd0);
    add_word(lpom_pkg::KIND_PIN, 1'b0, 1'b0, 32'd0, 32'hFFFF_FFFF);
    add_word(lpom_pkg::KIND_PIN, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'd0);
    add_word(lpom_pkg::KIND_READ, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'd1);
    add_word(lpom_pkg::KIND_PIN, 1'b1, 1'b0, 32'hFFFF_FFF0, 32'd0);
    add_word(lpom_pkg::KIND_PIN, 1'b1, 1'b1, 32'd16, 32'd0);
    add_word(lpom_pkg::KIND_READ, 1'b1, 1'b0, 32'd0, 32'hFFFF_FFFF);
    add_word(lpom_pkg::KIND_START, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'd5);
    add_word(lpom_pkg::KIND_READ, 1'b0, 1'b0, 32'd0, 32'd5);
    add_word(lpom_pkg::KIND_READ, 1'b1, 1'b0, 32'd0, 32'd1005);
    add_word(KIND_UNUSED, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_word(lpom_pkg::KIND_PIN, 1'b1, 1'b0, 32'd1000, 32'd0);
    add_word(lpom_pkg::KIND_PIN, 1'b1, 1'b1, 32'd501000, 32'd0);
    add_word(lpom_pkg::KIND_READ, 1'b1, 1'b1, 32'd0, 32'd2005);
    add_word(lpom_pkg::KIND_PIN, 1'b0, 1'b1, 32'd100, 32'd0);
    add_word(lpom_pkg::KIND_READ, 1'b0, 1'b1, 32'd0, 32'hFFFF_FFFF);
    add_word(lpom_pkg::KIND_START, 1'b0, 1'b0, 32'd0, 32'hFFFF_FFFF);
    add_word(lpom_pkg::KIND_READ, 1'b0, 1'b0, 32'd0, 32'd0);
    wait_idle();

    send_idle_pct = 8;
    recv_idle_pct = 73;
    add_random_words(150);
    wait_idle();

    // disabled: reads report zero, pins and starts still count
    write_enable(1'b0);
    add_word(lpom_pkg::KIND_PIN, 1'b0, 1'b0, sim_us, 32'd0);
    add_word(lpom_pkg::KIND_PIN, 1'b0, 1'b1, sim_us + 32'd40000, 32'd0);
    add_word(lpom_pkg::KIND_READ, 1'b0, 1'b0, 32'd0, sim_ms + 32'd7);
    add_word(lpom_pkg::KIND_READ, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_word(lpom_pkg::KIND_START, 1'b0, 1'b0, 32'd0, sim_ms);
    add_word(lpom_pkg::KIND_PIN, 1'b1, 1'b0, sim_us, 32'd0);
    add_word(lpom_pkg::KIND_PIN, 1'b1, 1'b1, sim_us + 32'd90000, 32'd0);
    add_word(lpom_pkg::KIND_READ, 1'b1, 1'b0, 32'd0, sim_ms);
    add_random_words(10);
    wait_idle();
    write_enable(1'b1);

    send_idle_pct = 73;
    recv_idle_pct = 8;
    add_random_words(130);
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random_words(120);
    wait_idle();

    if (err_count == 0) begin
      $display("tb_low_pulse_occupancy_meter: clean");
    end else begin
      $display("tb_low_pulse_occupancy_meter: errors");
    end
    $finish;
  end

endmodule
